@@ sv/slcfp_pkg.sv @@
// Shared types and constants for the sync/length/checksum frame parser.
package slcfp_pkg;

	// Reset value of the sync byte register
	localparam logic [7:0] SYNC_RESET = 8'hAA;

	// Result kinds
	localparam logic RES_PAYLOAD = 1'b0;
	localparam logic RES_FRAME_END = 1'b1;

	// Parse phases, one-hot
	typedef enum logic [5:0] {
		PH_SYNC   = 6'b000001,
		PH_LEN_H  = 6'b000010,
		PH_LEN_L  = 6'b000100,
		PH_OPCODE = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_CHECK  = 6'b100000
	} phase_t;

	// One result item
	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        storable;
		logic [7:0]  frame_opcode;
		logic [15:0] frame_length;
		logic        checksum_ok;
		logic        too_long;
	} result_t;

endpackage

@@ sv/slcfp_rx_if.sv @@
// Request channel carrying received bytes into the parser.
interface slcfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ sv/slcfp_res_if.sv @@
// Request channel carrying parser results out of the block.
interface slcfp_res_if;
	logic               valid;
	logic               ready;
	slcfp_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/sync_length_checksum_frame_parser.sv @@
// Frame parser top level: sync, 16-bit length, opcode, payload, additive checksum.
// Takes one received byte per cycle, except while a result is held up. Each byte
// goes through an input register, where the parse state is updated, and then
// into a result register, from which its result is offered. A byte that produces
// a result waits in the input register only while the result register is full
// and not being taken. Payload bytes come out with their index and a storable
// flag (index below MAX_PAYLOAD); the checksum byte gives a frame-end result with
// opcode, declared length, checksum-ok and too-long flags. The user must write the
// sync byte value via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module sync_length_checksum_frame_parser #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	slcfp_rx_if.sink          rx_ch,
	slcfp_res_if.source       res_ch
);

	localparam logic [16:0] MAX_P = 17'(MAX_PAYLOAD);

	logic [7:0]          sync_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                valid_s2;
	slcfp_pkg::result_t  result_s2;

	slcfp_pkg::phase_t   phase_q, phase_d;
	logic [7:0]          sum_q, sum_d;
	logic [15:0]         len_q, len_d;
	logic [15:0]         remain_q, remain_d;
	logic [15:0]         pos_q, pos_d;
	logic [7:0]          opcode_q, opcode_d;

	slcfp_pkg::result_t  result_d;
	logic                emit;
	logic                s2_load_ok;
	logic                s1_advance;
	logic [15:0]         remain_dec;
	logic [7:0]          check_sum;

	// Hold the sync byte value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= slcfp_pkg::SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// Handshake: advance stage 1 unless its result is blocked
	assign s2_load_ok = !valid_s2 || res_ch.ready;
	assign s1_advance = valid_s1 && (!emit || s2_load_ok);
	assign rx_ch.ready = !valid_s1 || s1_advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ch.ready) begin
			valid_s1 <= rx_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ch.valid && rx_ch.ready) begin
			byte_s1 <= rx_ch.rx_byte;
		end
	end

	assign remain_dec = remain_q - 16'd1;
	assign check_sum = sum_q + byte_s1;

	// Parse step for the byte in the input register
	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		len_d    = len_q;
		remain_d = remain_q;
		pos_d    = pos_q;
		opcode_d = opcode_q;
		result_d = '0;
		emit     = 1'b0;
		unique case (phase_q)
			slcfp_pkg::PH_LEN_H: begin
				sum_d   = check_sum;
				len_d   = {byte_s1, 8'h00};
				phase_d = slcfp_pkg::PH_LEN_L;
			end
			slcfp_pkg::PH_LEN_L: begin
				sum_d    = check_sum;
				len_d    = {len_q[15:8], byte_s1};
				remain_d = {len_q[15:8], byte_s1};
				phase_d  = slcfp_pkg::PH_OPCODE;
			end
			slcfp_pkg::PH_OPCODE: begin
				sum_d    = check_sum;
				opcode_d = byte_s1;
				pos_d    = 16'd0;
				phase_d  = (remain_q != 16'd0) ? slcfp_pkg::PH_DATA : slcfp_pkg::PH_CHECK;
			end
			slcfp_pkg::PH_DATA: begin
				emit                  = 1'b1;
				sum_d                 = check_sum;
				result_d.result_kind  = slcfp_pkg::RES_PAYLOAD;
				result_d.payload_byte = byte_s1;
				result_d.byte_index   = pos_q;
				result_d.storable     = ({1'b0, pos_q} < MAX_P);
				result_d.frame_opcode = opcode_q;
				result_d.frame_length = len_q;
				pos_d                 = pos_q + 16'd1;
				remain_d              = remain_dec;
				if (remain_dec == 16'd0) begin
					phase_d = slcfp_pkg::PH_CHECK;
				end
			end
			slcfp_pkg::PH_CHECK: begin
				emit                  = 1'b1;
				result_d.result_kind  = slcfp_pkg::RES_FRAME_END;
				result_d.frame_opcode = opcode_q;
				result_d.frame_length = len_q;
				result_d.checksum_ok  = (check_sum == 8'd0);
				result_d.too_long     = ({1'b0, len_q} > MAX_P);
				phase_d               = slcfp_pkg::PH_SYNC;
			end
			default: begin
				// Waiting for sync: drop anything else
				phase_d = slcfp_pkg::PH_SYNC;
				if (byte_s1 == sync_q) begin
					phase_d = slcfp_pkg::PH_LEN_H;
					sum_d   = 8'd0;
				end
			end
		endcase
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= slcfp_pkg::PH_SYNC;
			sum_q    <= 8'd0;
			len_q    <= 16'd0;
			remain_q <= 16'd0;
			pos_q    <= 16'd0;
			opcode_q <= 8'd0;
		end else if (s1_advance) begin
			phase_q  <= phase_d;
			sum_q    <= sum_d;
			len_q    <= len_d;
			remain_q <= remain_d;
			pos_q    <= pos_d;
			opcode_q <= opcode_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load_ok) begin
			valid_s2 <= s1_advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load_ok && s1_advance && emit) begin
			result_s2 <= result_d;
		end
	end

	assign res_ch.valid = valid_s2;
	assign res_ch.data  = result_s2;

endmodule

@@ tb/parser_scoreboard.sv @@
`timescale 1ns / 100ps
// Scoreboard for the frame parser: predicts results from accepted bytes and compares them.
module parser_scoreboard
	import slcfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	slcfp_rx_if        rx_mon,
	slcfp_res_if       res_mon,
	output int         mismatch_count,
	output int         pending_results
);

	// Parser state as the scoreboard tracks it
	logic [7:0]  sync_byte;
	phase_t      phase;
	logic [7:0]  byte_sum;
	logic [15:0] frame_len;
	logic [15:0] bytes_left;
	logic [15:0] payload_idx;
	logic [7:0]  opcode;

	result_t     predicted_results[$];
	int          errors;

	// Advance the parser by one byte; return 1 when the byte yields a result
	function automatic logic advance_parser(input logic [7:0] b, output result_t res);
		res = '0;
		advance_parser = 1'b0;
		case (phase)
			PH_LEN_H: begin
				byte_sum += b;
				frame_len = {b, 8'h00};
				phase = PH_LEN_L;
			end
			PH_LEN_L: begin
				byte_sum += b;
				frame_len = frame_len | {8'h00, b};
				bytes_left = frame_len;
				phase = PH_OPCODE;
			end
			PH_OPCODE: begin
				byte_sum += b;
				opcode = b;
				payload_idx = '0;
				phase = (bytes_left != 0) ? PH_DATA : PH_CHECK;
			end
			PH_DATA: begin
				byte_sum += b;
				res.result_kind = RES_PAYLOAD;
				res.payload_byte = b;
				res.byte_index = payload_idx;
				res.storable = ({16'h0000, payload_idx} < MAX_PAYLOAD);
				res.frame_opcode = opcode;
				res.frame_length = frame_len;
				payload_idx++;
				bytes_left--;
				if (bytes_left == 0) begin
					phase = PH_CHECK;
				end
				advance_parser = 1'b1;
			end
			PH_CHECK: begin
				res.result_kind = RES_FRAME_END;
				res.frame_opcode = opcode;
				res.frame_length = frame_len;
				res.checksum_ok = (8'(byte_sum + b) == 8'h00);
				res.too_long = ({16'h0000, frame_len} > MAX_PAYLOAD);
				phase = PH_SYNC;
				advance_parser = 1'b1;
			end
			default: begin
				// Hunt for the sync byte; anything else is dropped
				phase = PH_SYNC;
				if (b == sync_byte) begin
					phase = PH_LEN_H;
					byte_sum = 8'h00;
				end
			end
		endcase
	endfunction

	// Report one field that differs from the prediction
	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	// Match one delivered result against the oldest prediction
	function automatic void check_result(input result_t got);
		result_t want;
		if (predicted_results.size() == 0) begin
			$error("result with nothing predicted: kind %0h, opcode %0h, length %0h",
				got.result_kind, got.frame_opcode, got.frame_length);
			errors++;
			return;
		end
		want = predicted_results.pop_front();
		compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
		compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
		compare_field("byte_index", want.byte_index, got.byte_index);
		compare_field("storable", 16'(want.storable), 16'(got.storable));
		compare_field("frame_opcode", 16'(want.frame_opcode), 16'(got.frame_opcode));
		compare_field("frame_length", want.frame_length, got.frame_length);
		compare_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
		compare_field("too_long", 16'(want.too_long), 16'(got.too_long));
	endfunction

	// Watch both channels and the register port on every edge
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t predicted;
		if (!arst_n) begin
			sync_byte = SYNC_RESET;
			phase = PH_SYNC;
			byte_sum = 8'h00;
			frame_len = '0;
			bytes_left = '0;
			payload_idx = '0;
			opcode = 8'h00;
			predicted_results.delete();
			errors = 0;
			mismatch_count <= 0;
			pending_results <= 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				check_result(res_mon.data);
			end
			if (cfg_we) begin
				sync_byte = cfg_wdata;
			end
			if (rx_mon.valid && rx_mon.ready) begin
				if (advance_parser(rx_mon.rx_byte, predicted)) begin
					predicted_results.push_back(predicted);
				end
			end
			mismatch_count <= errors;
			pending_results <= predicted_results.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top for the frame parser: clock, reset, byte requests, result sink and verdict.
module testbench;
	import slcfp_pkg::*;

	localparam int MAX_PAYLOAD  = 1024;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {
		SINK_OPEN,
		SINK_MOSTLY,
		SINK_PERIODIC,
		SINK_COIN
	} sink_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic [7:0] sync_now = SYNC_RESET;
	logic       hold_req = 1'b0;
	logic       hold_done = 1'b0;
	int         mismatch_count;
	int         pending_results;
	int         bytes_sent = 0;
	int         burst_left = 0;
	int         cycle_count = 0;

	slcfp_rx_if  rx_ch();
	slcfp_res_if res_ch();

	sync_length_checksum_frame_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx_ch(rx_ch),
		.res_ch(res_ch)
	);

	parser_scoreboard #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx_mon(rx_ch),
		.res_mon(res_ch),
		.mismatch_count(mismatch_count),
		.pending_results(pending_results)
	);

	always #2 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one byte and hold it until the parser takes the request
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Stop offering and wait until every predicted result has come out
	task automatic pause_until_drained();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Change the sync byte while the parser is idle
	task automatic write_sync(input logic [7:0] value);
		pause_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sync_now = value;
	endtask

	// Send a whole frame; payload is random with the sync value mixed in
	task automatic send_frame(input logic [15:0] len, input logic [7:0] op, input logic bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		send_byte(sync_now);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(op);
		sum = len[15:8] + len[7:0] + op;
		for (int i = 0; i < len; i++) begin
			b = ($urandom_range(0, 7) == 0) ? sync_now : 8'($urandom_range(0, 255));
			sum += b;
			send_byte(b);
		end
		b = -sum;
		if (bad_sum) begin
			b ^= 8'($urandom_range(1, 255));
		end
		send_byte(b);
	endtask

	// Mostly short frames with the odd bad checksum and line noise between them
	task automatic run_random(input int target);
		int noise;
		int len;
		logic [7:0] n;
		while (bytes_sent < target) begin
			noise = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
			repeat (noise) begin
				// keep noise off the sync value so frames stay aligned
				n = 8'($urandom_range(0, 255));
				if (n == sync_now) begin
					n = ~n;
				end
				send_byte(n);
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
			send_frame(16'(len), 8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
		end
	endtask

	// Result sink: segments of open, mostly open, periodic and coin-flip ready
	initial begin : result_sink
		int seg_len;
		int period;
		sink_mode_t mode;
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				// hold off long enough for the parser to back up into its input
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				seg_len = $urandom_range(8, 120);
				mode = sink_mode_t'($urandom_range(0, 3));
				period = $urandom_range(2, 6);
				for (int k = 0; k < seg_len; k++) begin
					case (mode)
						SINK_OPEN: res_ch.ready <= 1'b1;
						SINK_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
						SINK_PERIODIC: res_ch.ready <= (k % period == 0);
						default: res_ch.ready <= 1'($urandom_range(0, 1));
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Byte source and verdict
	initial begin : stimulus
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ignored bytes while hunting, then zero-length, bad-checksum and short frames
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(~SYNC_RESET);
		send_frame(16'd0, 8'hFF, 1'b0);
		send_frame(16'd0, 8'h00, 1'b1);
		send_frame(16'd1, 8'h80, 1'b0);
		send_frame(16'd3, SYNC_RESET, 1'b1);

		run_random(350);
		write_sync(8'h00);
		run_random(650);

		// One frame just past the payload limit, with the sink held off at first
		write_sync(8'hFF);
		hold_req <= 1'b1;
		send_frame(16'(MAX_PAYLOAD + 1), 8'($urandom_range(0, 255)), 1'b0);
		pause_until_drained();

		write_sync(8'($urandom_range(1, 254)));
		run_random(1800);
		write_sync(SYNC_RESET);
		run_random(1950);

		pause_until_drained();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
